>>> hw/rtl/mmq_pkg.sv
// Shared types and constants for the message match queue.
package mmq_pkg;

  localparam int TableDepth = 16;
  localparam int RankBits   = 8;

  typedef enum logic [1:0] {
    KIND_SEND    = 2'd0,
    KIND_BCAST   = 2'd1,
    KIND_SCATTER = 2'd2,
    KIND_INVALID = 2'd3
  } kind_t;

  typedef enum logic {
    OP_ARRIVE = 1'b0,
    OP_POST   = 1'b1
  } op_t;

  typedef struct packed {
    kind_t                kind;
    logic [RankBits-1:0]  src;
    logic [31:0]          size;
    logic [31:0]          seq;
    logic [31:0]          res;
  } entry_t;

  typedef struct packed {
    logic                 valid;
    kind_t                kind;
    logic [RankBits-1:0]  peer;
    logic                 any;
    logic [31:0]          size;
  } req_t;

  typedef struct packed {
    logic wr;
    logic srch;
  } cell_ctl_t;

endpackage

>>> hw/rtl/message_match_queue.sv
// Top level of the message match queue: request register, cell row and result beat.
//
// The block keeps an ordered table of unexpected messages and one posted
// request. Each in_ beat is either an arriving message (in_operation = 0),
// appended at the tail of the table, or a posted request (in_operation = 1),
// which replaces any pending one. Every in_ beat yields exactly one out_
// beat: out_matched when the oldest agreeing entry was removed (its source,
// sequence and result word are returned, otherwise these are zero), and
// out_dropped when an arrival found the table full. Kind code three is
// ignored and yields an all-zero result.
// For each item, the accept cycle writes the tail cell or the request register,
// and the next cycle runs the compare along the row of cells, removes the hit
// and loads the result register. The found flag and the gathered entry ripple
// through the cells, which sets the cycle length. A new item is not taken
// while the previous one is being searched, even when out_ready stays high.
// Reset empties the table and clears the pending request and the result valid flag.
// While out_valid waits for out_ready no new item is taken.
module message_match_queue (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_operation,
  input  logic [1:0]  in_msg_kind,
  input  logic [7:0]  in_peer_rank,
  input  logic        in_any_peer,
  input  logic [31:0] in_byte_count,
  input  logic [31:0] in_seq_number,
  input  logic [31:0] in_carried_result,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_matched,
  output logic        out_dropped,
  output logic [7:0]  out_match_source,
  output logic [31:0] out_match_sequence,
  output logic [31:0] out_match_result
);

  localparam int D = mmq_pkg::TableDepth;
  localparam int R = mmq_pkg::RankBits;

  logic               busy_r, busy_nxt;
  logic               skip_r, skip_nxt;
  logic               drop_r, drop_nxt;
  mmq_pkg::req_t      req_r, req_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               out_matched_r, out_matched_nxt;
  logic               out_dropped_r, out_dropped_nxt;
  logic [7:0]         out_source_r, out_source_nxt;
  logic [31:0]        out_seq_r, out_seq_nxt;
  logic [31:0]        out_res_r, out_res_nxt;

  logic               accept;
  logic               kind_ok;
  mmq_pkg::cell_ctl_t ctl;
  mmq_pkg::entry_t    wdata;
  logic [D-1:0]       valid_w;
  mmq_pkg::entry_t    ent_w   [D];
  logic [D:0]         found_w;
  mmq_pkg::entry_t    acc_w   [D+1];
  mmq_pkg::entry_t    empty_ent;

  assign in_ready = !busy_r && (!out_valid_r || out_ready);
  assign accept   = in_valid && in_ready;
  assign kind_ok  = (in_msg_kind != mmq_pkg::KIND_INVALID);

  always_comb begin
    empty_ent  = '0;
    wdata.kind = mmq_pkg::kind_t'(in_msg_kind);
    wdata.src  = in_peer_rank[R-1:0];
    wdata.size = in_byte_count;
    wdata.seq  = in_seq_number;
    wdata.res  = in_carried_result;
    ctl.wr   = accept && kind_ok && (in_operation == mmq_pkg::OP_ARRIVE);
    ctl.srch = busy_r && !skip_r && req_r.valid;
  end

  assign found_w[0] = 1'b0;
  assign acc_w[0]   = '0;

  for (genvar i = 0; i < D; i++) begin : g_cell
    logic            prev_v;
    logic            yng_v;
    mmq_pkg::entry_t yng;
    if (i == 0) begin : g_head
      assign prev_v = 1'b1;
    end else begin : g_mid
      assign prev_v = valid_w[i-1];
    end
    if (i == D - 1) begin : g_tail
      assign yng_v = 1'b0;
      assign yng   = empty_ent;
    end else begin : g_body
      assign yng_v = valid_w[i+1];
      assign yng   = ent_w[i+1];
    end
    mmq_cell u_cell (
      .clk             (clk),
      .rst_n           (rst_n),
      .ctl             (ctl),
      .wdata           (wdata),
      .req             (req_r),
      .prev_valid_i    (prev_v),
      .younger_valid_i (yng_v),
      .younger_i       (yng),
      .found_i         (found_w[i]),
      .acc_i           (acc_w[i]),
      .valid_o         (valid_w[i]),
      .ent_o           (ent_w[i]),
      .found_o         (found_w[i+1]),
      .acc_o           (acc_w[i+1])
    );
  end

  always_comb begin
    busy_nxt        = busy_r;
    skip_nxt        = skip_r;
    drop_nxt        = drop_r;
    req_nxt         = req_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    out_matched_nxt = out_matched_r;
    out_dropped_nxt = out_dropped_r;
    out_source_nxt  = out_source_r;
    out_seq_nxt     = out_seq_r;
    out_res_nxt     = out_res_r;
    if (accept) begin
      busy_nxt = 1'b1;
      skip_nxt = !kind_ok;
      drop_nxt = kind_ok && (in_operation == mmq_pkg::OP_ARRIVE) && valid_w[D-1];
      if (kind_ok && (in_operation == mmq_pkg::OP_POST)) begin
        req_nxt.valid = 1'b1;
        req_nxt.kind  = mmq_pkg::kind_t'(in_msg_kind);
        req_nxt.peer  = in_peer_rank[R-1:0];
        req_nxt.any   = in_any_peer;
        req_nxt.size  = in_byte_count;
      end
    end
    if (busy_r) begin
      busy_nxt        = 1'b0;
      out_valid_nxt   = 1'b1;
      out_matched_nxt = found_w[D];
      out_dropped_nxt = drop_r;
      out_source_nxt  = 8'(acc_w[D].src);
      out_seq_nxt     = acc_w[D].seq;
      out_res_nxt     = acc_w[D].res;
      if (found_w[D]) begin
        req_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      skip_r      <= 1'b0;
      drop_r      <= 1'b0;
      req_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      skip_r      <= skip_nxt;
      drop_r      <= drop_nxt;
      req_r       <= req_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_matched_r <= out_matched_nxt;
    out_dropped_r <= out_dropped_nxt;
    out_source_r  <= out_source_nxt;
    out_seq_r     <= out_seq_nxt;
    out_res_r     <= out_res_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_matched        = out_matched_r;
  assign out_dropped        = out_dropped_r;
  assign out_match_source   = out_source_r;
  assign out_match_sequence = out_seq_r;
  assign out_match_result   = out_res_r;

  a_compact: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_w[D-1:1] & ~valid_w[D-2:0]) == '0)
    else $error("table holes between valid slots");

  a_req_clear: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && found_w[D] |=> !req_r.valid)
    else $error("request not cleared after match");

  a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && drop_r |-> valid_w[D-1] && !found_w[D])
    else $error("drop without full table or with match");

  a_one_flight: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> !in_ready)
    else $error("second item accepted during search");

endmodule

>>> hw/rtl/mmq_cell.sv
// One slot of the unexpected-message table: take a write, compare, gather and shift down.
module mmq_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  mmq_pkg::cell_ctl_t ctl,
  input  mmq_pkg::entry_t   wdata,
  input  mmq_pkg::req_t     req,
  input  logic              prev_valid_i,
  input  logic              younger_valid_i,
  input  mmq_pkg::entry_t   younger_i,
  input  logic              found_i,
  input  mmq_pkg::entry_t   acc_i,
  output logic              valid_o,
  output mmq_pkg::entry_t   ent_o,
  output logic              found_o,
  output mmq_pkg::entry_t   acc_o
);

  logic            valid_r;
  logic            valid_nxt;
  mmq_pkg::entry_t data_r;
  mmq_pkg::entry_t data_nxt;
  logic            hit;
  logic            take_w;
  logic            shift;

  always_comb begin
    hit = ctl.srch && valid_r && !found_i && (data_r.kind == req.kind)
          && (data_r.size == req.size) && (req.any || (data_r.src == req.peer));
    take_w = ctl.wr && !valid_r && prev_valid_i;
    shift  = ctl.srch && (found_i || hit);
    valid_nxt = valid_r;
    data_nxt  = data_r;
    if (shift) begin
      valid_nxt = younger_valid_i;
      data_nxt  = younger_i;
    end else if (take_w) begin
      valid_nxt = 1'b1;
      data_nxt  = wdata;
    end
    found_o = found_i || hit;
    acc_o   = hit ? (acc_i | data_r) : acc_i;
    valid_o = valid_r;
    ent_o   = data_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

endmodule

>>> verif/tb_message_match_queue.sv
// Self-checking bench for the message match queue: stimulus queue, predictor and checker.
module tb_message_match_queue;

  localparam int CycleLimit  = 400000;
  localparam int RandomItems = 1400;
  localparam int TailCycles  = 12;

  typedef struct {
    mmq_pkg::op_t   op;
    mmq_pkg::kind_t kind;
    logic [7:0]     peer;
    logic           any;
    logic [31:0]    size;
    logic [31:0]    seq;
    logic [31:0]    res;
    bit             drain_first;
  } msg_item_t;

  typedef struct packed {
    logic        matched;
    logic        dropped;
    logic [7:0]  src;
    logic [31:0] seq;
    logic [31:0] res;
  } match_beat_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_operation = 1'b0;
  logic [1:0]  in_msg_kind = 2'd0;
  logic [7:0]  in_peer_rank = 8'd0;
  logic        in_any_peer = 1'b0;
  logic [31:0] in_byte_count = 32'd0;
  logic [31:0] in_seq_number = 32'd0;
  logic [31:0] in_carried_result = 32'd0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_matched;
  logic        out_dropped;
  logic [7:0]  out_match_source;
  logic [31:0] out_match_sequence;
  logic [31:0] out_match_result;

  msg_item_t   pending_msgs[$];
  match_beat_t match_results_due[$];
  msg_item_t   recent_arrivals[$];
  msg_item_t   on_wire;
  match_beat_t predicted;
  match_beat_t seen;

  mmq_pkg::entry_t held_msgs[mmq_pkg::TableDepth];
  int              n_held = 0;
  mmq_pkg::req_t   posted_req = '0;

  int          total_items = 0;
  int          n_accepted = 0;
  int          n_results = 0;
  int          n_matches = 0;
  int          n_drops = 0;
  int          n_ignored = 0;
  int          n_errors = 0;
  int          cycle_count = 0;

  message_match_queue i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_operation       (in_operation),
    .in_msg_kind        (in_msg_kind),
    .in_peer_rank       (in_peer_rank),
    .in_any_peer        (in_any_peer),
    .in_byte_count      (in_byte_count),
    .in_seq_number      (in_seq_number),
    .in_carried_result  (in_carried_result),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_matched        (out_matched),
    .out_dropped        (out_dropped),
    .out_match_source   (out_match_source),
    .out_match_sequence (out_match_sequence),
    .out_match_result   (out_match_result)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic match_beat_t step_match_table(msg_item_t it);
    match_beat_t b;
    int          hit;
    b = '0;
    hit = -1;
    if (it.kind == mmq_pkg::KIND_INVALID) begin
      n_ignored++;
      return b;
    end
    if (it.op == mmq_pkg::OP_ARRIVE) begin
      if (n_held >= mmq_pkg::TableDepth) begin
        b.dropped = 1'b1;
      end else begin
        held_msgs[n_held] = '{kind: it.kind, src: it.peer, size: it.size, seq: it.seq,
                              res: it.res};
        n_held++;
      end
    end else begin
      posted_req = '{valid: 1'b1, kind: it.kind, peer: it.peer, any: it.any,
                     size: it.size};
    end
    if (posted_req.valid) begin
      for (int i = 0; i < n_held; i++) begin
        if (hit < 0 && held_msgs[i].kind == posted_req.kind
            && held_msgs[i].size == posted_req.size
            && (posted_req.any || held_msgs[i].src == posted_req.peer)) begin
          hit = i;
        end
      end
      if (hit >= 0) begin
        b.matched = 1'b1;
        b.src     = held_msgs[hit].src;
        b.seq     = held_msgs[hit].seq;
        b.res     = held_msgs[hit].res;
        for (int i = hit; i < n_held - 1; i++) begin
          held_msgs[i] = held_msgs[i + 1];
        end
        n_held--;
        posted_req = '0;
      end
    end
    if (b.matched) n_matches++;
    if (b.dropped) n_drops++;
    return b;
  endfunction

  function automatic int send_idle_pct();
    if (n_accepted < total_items / 3) return 13;
    if (n_accepted < (2 * total_items) / 3) return 51;
    return 0;
  endfunction

  function automatic int recv_idle_pct();
    if (n_accepted < total_items / 3) return 51;
    if (n_accepted < (2 * total_items) / 3) return 13;
    return 0;
  endfunction

  task automatic note_failure(string what);
    n_errors++;
    if (n_errors <= 10) $display("mismatch at beat %0d: %s", n_results, what);
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) note_failure($sformatf("%s expected %h got %h", name, want, got));
  endtask

  task automatic push_item(mmq_pkg::op_t op, mmq_pkg::kind_t kind, logic [7:0] peer,
                           logic any, logic [31:0] size, logic [31:0] seq,
                           logic [31:0] res, bit drain_first);
    msg_item_t it;
    it = '{op: op, kind: kind, peer: peer, any: any, size: size, seq: seq, res: res,
           drain_first: drain_first};
    pending_msgs.insert(pending_msgs.size(), it);
  endtask

  function automatic logic [7:0] pick_peer();
    logic [7:0] peer_pool[4] = '{8'h00, 8'h5A, 8'hA5, 8'hFF};
    if ($urandom_range(99) < 15) return 8'($urandom);
    return peer_pool[$urandom_range(3)];
  endfunction

  function automatic logic [31:0] pick_size();
    logic [31:0] size_pool[4] = '{32'h0, 32'h10, 32'h5DC, 32'hFFFF_FFFF};
    if ($urandom_range(99) < 15) return $urandom;
    return size_pool[$urandom_range(3)];
  endfunction

  task automatic fill_random();
    msg_item_t src_msg;
    int        n_real;
    int        r;
    n_real = 0;
    while (n_real < RandomItems) begin
      r = $urandom_range(99);
      if (r < 8) begin
        push_item(mmq_pkg::op_t'($urandom_range(1)), mmq_pkg::kind_t'($urandom_range(3)),
                  8'($urandom), 1'($urandom), $urandom, $urandom, $urandom, 1'b0);
      end else if (r < 53) begin
        push_item(mmq_pkg::OP_ARRIVE, mmq_pkg::kind_t'($urandom_range(2)), pick_peer(),
                  1'($urandom), pick_size(), $urandom, $urandom, $urandom_range(99) == 0);
        recent_arrivals.insert(recent_arrivals.size(), pending_msgs[$]);
        if (recent_arrivals.size() > 8) void'(recent_arrivals.pop_front());
      end else if (recent_arrivals.size() > 0 && $urandom_range(99) < 60) begin
        src_msg = recent_arrivals[$urandom_range(recent_arrivals.size() - 1)];
        push_item(mmq_pkg::OP_POST, src_msg.kind, src_msg.peer, $urandom_range(99) < 25,
                  src_msg.size, $urandom, $urandom, 1'b0);
      end else begin
        push_item(mmq_pkg::OP_POST, mmq_pkg::kind_t'($urandom_range(2)), pick_peer(),
                  $urandom_range(99) < 25, pick_size(), $urandom, $urandom, 1'b0);
      end
      if (pending_msgs[$].kind != mmq_pkg::KIND_INVALID) n_real++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predicted = step_match_table(on_wire);
        match_results_due.insert(match_results_due.size(), predicted);
        n_accepted++;
      end
      if (!(in_valid && !in_ready)) begin
        if (pending_msgs.size() > 0 && $urandom_range(99) >= send_idle_pct()
            && !(pending_msgs[0].drain_first && match_results_due.size() != 0)) begin
          on_wire           = pending_msgs.pop_front();
          in_operation      <= on_wire.op;
          in_msg_kind       <= on_wire.kind;
          in_peer_rank      <= on_wire.peer;
          in_any_peer       <= on_wire.any;
          in_byte_count     <= on_wire.size;
          in_seq_number     <= on_wire.seq;
          in_carried_result <= on_wire.res;
          in_valid          <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        seen = '{matched: out_matched, dropped: out_dropped, src: out_match_source,
                 seq: out_match_sequence, res: out_match_result};
        if (match_results_due.size() == 0) begin
          note_failure("result beat with nothing outstanding");
        end else begin
          predicted = match_results_due.pop_front();
          check_field("matched", 32'(predicted.matched), 32'(seen.matched));
          check_field("dropped", 32'(predicted.dropped), 32'(seen.dropped));
          check_field("match_source", 32'(predicted.src), 32'(seen.src));
          check_field("match_sequence", predicted.seq, seen.seq);
          check_field("match_result", predicted.res, seen.res);
        end
        n_results++;
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct());
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d of %0d beats accepted", cycle_count,
               n_accepted, total_items);
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    push_item(mmq_pkg::OP_POST, mmq_pkg::KIND_SEND, 8'd5, 1'b0, 32'd100, 32'd0, 32'd0,
              1'b0);
    push_item(mmq_pkg::OP_ARRIVE, mmq_pkg::KIND_INVALID, 8'hFF, 1'b1, '1, '1, '1, 1'b0);
    push_item(mmq_pkg::OP_POST, mmq_pkg::KIND_INVALID, 8'hFF, 1'b1, '1, '1, '1, 1'b0);
    push_item(mmq_pkg::OP_ARRIVE, mmq_pkg::KIND_SEND, 8'd5, 1'b0, 32'd100, 32'h1, 32'hA5,
              1'b0);
    push_item(mmq_pkg::OP_POST, mmq_pkg::KIND_SEND, 8'd7, 1'b0, 32'd42, 32'd0, 32'd0,
              1'b1);
    push_item(mmq_pkg::OP_POST, mmq_pkg::KIND_SEND, 8'd9, 1'b0, 32'd42, 32'd0, 32'd0,
              1'b0);
    push_item(mmq_pkg::OP_ARRIVE, mmq_pkg::KIND_SEND, 8'd7, 1'b0, 32'd42, 32'h2, 32'h5A,
              1'b0);
    push_item(mmq_pkg::OP_ARRIVE, mmq_pkg::KIND_BCAST, 8'h00, 1'b0, 32'h0, 32'h0, 32'h0,
              1'b0);
    push_item(mmq_pkg::OP_ARRIVE, mmq_pkg::KIND_SCATTER, 8'hFF, 1'b1, '1, '1, '1, 1'b0);
    push_item(mmq_pkg::OP_ARRIVE, mmq_pkg::KIND_SCATTER, 8'd3, 1'b0, 32'd7, 32'h100, 32'h1,
              1'b0);
    for (int i = 0; i < 11; i++) begin
      push_item(mmq_pkg::OP_ARRIVE, (i % 2) ? mmq_pkg::KIND_SCATTER : mmq_pkg::KIND_BCAST,
                8'(i + 16), 1'b0, 32'h1000 + i, $urandom, $urandom, 1'b0);
    end
    push_item(mmq_pkg::OP_ARRIVE, mmq_pkg::KIND_SCATTER, 8'd3, 1'b0, 32'd7, 32'h200, 32'h2,
              1'b0);
    push_item(mmq_pkg::OP_ARRIVE, mmq_pkg::KIND_SEND, 8'd9, 1'b0, 32'd42, 32'h3, 32'h3,
              1'b0);
    push_item(mmq_pkg::OP_POST, mmq_pkg::KIND_SCATTER, 8'h00, 1'b1, '1, 32'd0, 32'd0,
              1'b1);
    push_item(mmq_pkg::OP_POST, mmq_pkg::KIND_BCAST, 8'h00, 1'b0, 32'h0, 32'd0, 32'd0,
              1'b0);
    push_item(mmq_pkg::OP_POST, mmq_pkg::KIND_SCATTER, 8'd3, 1'b0, 32'd7, 32'd0, 32'd0,
              1'b0);
    fill_random();
    total_items = pending_msgs.size();

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    while (n_accepted < total_items || match_results_due.size() != 0) @(posedge clk);
    repeat (TailCycles) @(posedge clk);
    if (match_results_due.size() != 0) note_failure("expected results left outstanding");

    $display("covered %0d beats in %0d cycles: %0d matches, %0d drops, %0d ignored kinds",
             n_accepted, cycle_count, n_matches, n_drops, n_ignored);
    $display("%0d result beats checked, %0d failures", n_results, n_errors);
    if (n_errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
